// ----- src/modbus_request_ban_filter_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Modbus request ban filter
// Shared wrappers for concurrent assertions, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef MODBUS_REQUEST_BAN_FILTER_CORE_ASSERT_SVH
`define MODBUS_REQUEST_BAN_FILTER_CORE_ASSERT_SVH

// Same-cycle implication
`define MRBF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("mrbf same-cycle check failed");

// Next-cycle implication
`define MRBF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("mrbf next-cycle check failed");

`endif

// ----- src/mrbf_pkg.sv -----
// ----------------------------------------------------------------------------
// mrbf_pkg
// Types, constants and helpers shared by the ban filter modules.
// ----------------------------------------------------------------------------
package mrbf_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Configuration register indexes
  localparam logic [1:0] REG_ERROR_THRESHOLD  = 2'd0;
  localparam logic [1:0] REG_BAN_SECONDS      = 2'd1;
  localparam logic [1:0] REG_REGISTER_WINDOW  = 2'd2;
  localparam logic [1:0] REG_ALLOWED_FUNCTION = 2'd3;

  // Reset values of the configuration registers
  localparam logic [7:0]  RST_ERROR_THRESHOLD  = 8'd5;
  localparam logic [15:0] RST_BAN_SECONDS      = 16'd300;
  localparam logic [15:0] RST_REGISTER_WINDOW  = 16'd4;
  localparam logic [7:0]  RST_ALLOWED_FUNCTION = 8'd3;

  // Verdict codes
  localparam logic [1:0] V_ACCEPT   = 2'd0;
  localparam logic [1:0] V_BANNED   = 2'd1;
  localparam logic [1:0] V_BAD_FUNC = 2'd2;
  localparam logic [1:0] V_BAD_ADDR = 2'd3;

  localparam logic [7:0]  CNT_MAX = 8'hFF;
  localparam logic [31:0] DL_MAX  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        mode;
    logic [31:0] src_ip;
    logic [31:0] now_seconds;
    logic [7:0]  function_code;
    logic [15:0] start_addr;
    logic [15:0] reg_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic        ban_started;
    logic [3:0]  entry_slot;
    logic [31:0] ban_deadline;
  } out_item_t;

  // Search token that walks down the cell row
  typedef struct packed {
    logic             valid;
    logic [31:0]      ip;
    logic             mhit;   // exact address match found
    logic [IDX_W-1:0] midx;
    logic [7:0]       mcnt;
    logic [31:0]      mdl;
    logic             fhit;   // free entry found
    logic [IDX_W-1:0] fidx;
    logic [7:0]       fcnt;
    logic [31:0]      fdl;
  } token_t;

  // Entry update broadcast to the row
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [31:0]      addr;
    logic [7:0]       cnt;
    logic [31:0]      dl;
  } wr_t;

  // Low four bits of an entry index
  function automatic logic [3:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+3:0] ext;
    ext = {4'b0000, idx};
    return ext[3:0];
  endfunction

endpackage

// ----- src/modbus_request_ban_filter_core.sv -----
// ----------------------------------------------------------------------------
// modbus_request_ban_filter_core
// Client ban filter for a Modbus server: a row of table cells searched by a
// token that steps one cell per clock.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_data and raise start; the item transfers on a rising
//   edge with start high and busy low. busy stays high while the search runs.
//   Output: one result per item, shown on out_data for a single cycle with
//   out_valid high. The receiver cannot hold it off; it must take it then.
//   Search: the token passes one cell per clock, the first cell taking it at
//   the transfer edge; when it leaves the last cell, out_valid and out_data
//   are registered at the same edge that updates the chosen entry.
//   A new item cannot transfer while a search runs; it may transfer in the
//   cycle out_valid is high.
//   Configuration: cfg_we, cfg_idx, cfg_wdata write a register. The user
//   must write only while busy is low and no result is pending; the block
//   itself does not enforce it.
//   Reset: rst_n low clears the table to free entries and loads the
//   configuration defaults; the block is ready the cycle after.
// ----------------------------------------------------------------------------
module modbus_request_ban_filter_core
  import mrbf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  token_t tok [0:TABLE_ENTRIES];
  wr_t    wr;

  mrbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .tok_o     (tok[0]),
    .tok_i     (tok[TABLE_ENTRIES]),
    .wr_o      (wr)
  );

  // Cell row, token hands on from cell to cell
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    mrbf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(g)),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1]),
      .wr_i     (wr)
    );
  end

endmodule

// ----- src/mrbf_cell.sv -----
// ----------------------------------------------------------------------------
// mrbf_cell
// One table entry: compares the passing search token against its address and
// hands the token on, and takes updates addressed to its own index.
// ----------------------------------------------------------------------------
module mrbf_cell
  import mrbf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  token_t           tok_i,
  output token_t           tok_o,
  input  wr_t              wr_i
);

  logic [31:0] addr_r, addr_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [31:0] dl_r, dl_nxt;
  token_t      tok_r, tok_nxt;

  // Record first match and first free entry into the token
  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.valid && !tok_i.mhit && (addr_r == tok_i.ip)) begin
      tok_nxt.mhit = 1'b1;
      tok_nxt.midx = cell_idx;
      tok_nxt.mcnt = cnt_r;
      tok_nxt.mdl  = dl_r;
    end
    if (tok_i.valid && !tok_i.fhit && (addr_r == 32'd0)) begin
      tok_nxt.fhit = 1'b1;
      tok_nxt.fidx = cell_idx;
      tok_nxt.fcnt = cnt_r;
      tok_nxt.fdl  = dl_r;
    end
  end

  // Apply an update aimed at this entry
  always_comb begin
    addr_nxt = addr_r;
    cnt_nxt  = cnt_r;
    dl_nxt   = dl_r;
    if (wr_i.en && (wr_i.idx == cell_idx)) begin
      addr_nxt = wr_i.addr;
      cnt_nxt  = wr_i.cnt;
      dl_nxt   = wr_i.dl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      cnt_r  <= '0;
      dl_r   <= '0;
      tok_r  <= '0;
    end else begin
      addr_r <= addr_nxt;
      cnt_r  <= cnt_nxt;
      dl_r   <= dl_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// ----- src/mrbf_ctrl.sv -----
// ----------------------------------------------------------------------------
// mrbf_ctrl
// Holds configuration, takes items, launches the search token and, when it
// leaves the row, decides the verdict and issues the entry update.
// ----------------------------------------------------------------------------
module mrbf_ctrl
  import mrbf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata,
  output token_t      tok_o,
  input  token_t      tok_i,
  output wr_t         wr_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic        state_r, state_nxt;
  logic [7:0]  thr_r;
  logic [15:0] ban_r;
  logic [15:0] win_r;
  logic [7:0]  func_r;

  logic        mode_r;
  logic [31:0] now_r;
  logic [31:0] dlsat_r;
  logic [1:0]  viol_r;

  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic        accept;
  logic [32:0] dl_sum;
  logic [31:0] dl_sat;
  logic [16:0] win_sum;
  logic [1:0]  viol;

  logic [IDX_W-1:0] sel_idx;
  logic [7:0]       sel_cnt;
  logic [31:0]      sel_dl;
  logic [7:0]       inc_cnt;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Precompute saturated deadline and violation class at accept
  always_comb begin
    dl_sum  = {1'b0, in_data.now_seconds} + {17'd0, ban_r};
    dl_sat  = dl_sum[32] ? DL_MAX : dl_sum[31:0];
    win_sum = {1'b0, in_data.start_addr} + {1'b0, in_data.reg_count};
    if (in_data.function_code != func_r) begin
      viol = V_BAD_FUNC;
    end else if (win_sum > {1'b0, win_r}) begin
      viol = V_BAD_ADDR;
    end else begin
      viol = V_ACCEPT;
    end
  end

  // Launch the token into the first cell
  always_comb begin
    tok_o       = '0;
    tok_o.valid = accept;
    tok_o.ip    = in_data.src_ip;
  end

  // Pick the violation target: match, else first free, else entry zero cleared
  always_comb begin
    if (tok_i.mhit) begin
      sel_idx = tok_i.midx;
      sel_cnt = tok_i.mcnt;
      sel_dl  = tok_i.mdl;
    end else if (tok_i.fhit) begin
      sel_idx = tok_i.fidx;
      sel_cnt = tok_i.fcnt;
      sel_dl  = tok_i.fdl;
    end else begin
      sel_idx = '0;
      sel_cnt = '0;
      sel_dl  = '0;
    end
    inc_cnt = (sel_cnt == CNT_MAX) ? CNT_MAX : sel_cnt + 8'd1;
  end

  // Decide verdict and entry update when the token leaves the row
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    wr_o          = '0;
    wr_o.addr     = tok_i.ip;
    if (accept) begin
      state_nxt = ST_SCAN;
    end
    if ((state_r == ST_SCAN) && tok_i.valid) begin
      state_nxt     = ST_IDLE;
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      if (!mode_r) begin
        if (tok_i.mhit) begin
          out_data_nxt.entry_slot = to_slot(tok_i.midx);
          if (tok_i.mdl > now_r) begin
            out_data_nxt.verdict      = V_BANNED;
            out_data_nxt.ban_deadline = tok_i.mdl;
          end else begin
            wr_o.en  = 1'b1;
            wr_o.idx = tok_i.midx;
          end
        end
      end else if (viol_r != V_ACCEPT) begin
        out_data_nxt.verdict    = viol_r;
        out_data_nxt.entry_slot = to_slot(sel_idx);
        wr_o.en  = 1'b1;
        wr_o.idx = sel_idx;
        if (inc_cnt >= thr_r) begin
          out_data_nxt.ban_started  = 1'b1;
          out_data_nxt.ban_deadline = dlsat_r;
          wr_o.cnt = '0;
          wr_o.dl  = dlsat_r;
        end else begin
          out_data_nxt.ban_deadline = sel_dl;
          wr_o.cnt = inc_cnt;
          wr_o.dl  = sel_dl;
        end
      end
    end
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      thr_r       <= RST_ERROR_THRESHOLD;
      ban_r       <= RST_BAN_SECONDS;
      win_r       <= RST_REGISTER_WINDOW;
      func_r      <= RST_ALLOWED_FUNCTION;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_ERROR_THRESHOLD:  thr_r  <= cfg_wdata[7:0];
          REG_BAN_SECONDS:      ban_r  <= cfg_wdata;
          REG_REGISTER_WINDOW:  win_r  <= cfg_wdata;
          REG_ALLOWED_FUNCTION: func_r <= cfg_wdata[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      mode_r  <= in_data.mode;
      now_r   <= in_data.now_seconds;
      dlsat_r <= dl_sat;
      viol_r  <= viol;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/mrbf_checker.sv -----
// ----------------------------------------------------------------------------
// mrbf_checker
// Port-level checks on the ban filter's command and result behavior.
// ----------------------------------------------------------------------------
`include "modbus_request_ban_filter_core_assert.svh"

module mrbf_checker
  import mrbf_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_data
);

  // A transfer starts a search
  `MRBF_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

  // A result ends the search
  `MRBF_ASSERT_NOW(a_result_idle, clk, rst_n, out_valid, !busy)

  // One result per item, never two in a row
  `MRBF_ASSERT_NEXT(a_single_result, clk, rst_n, out_valid, !out_valid)

  // Only a violation can start a ban
  `MRBF_ASSERT_NOW(a_ban_on_violation, clk, rst_n, out_valid && out_data.ban_started,
    out_data.verdict == V_BAD_FUNC || out_data.verdict == V_BAD_ADDR)

endmodule

bind modbus_request_ban_filter_core mrbf_checker u_mrbf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
